FILE: rtl/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the stepper pulse generator
// per-motor state record, reset values, register indexes, motor update
// functions
// ----------------------------------------------------------------------------
package msp_pkg;

  // default geometry
  localparam int MOTORS_DEF     = 4;
  localparam int PACKET_LEN_DEF = 7;

  // first packet byte that carries a motor speed
  localparam int SPEED_BASE = 3;

  // reset values
  localparam logic [7:0]  RESET_PERIOD = 8'd100;
  localparam logic [15:0] RESET_RUN    = 16'd200;
  localparam logic [15:0] RESET_HEADER = 16'h4994;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD = CFG_IDX_W'(1);

  // state of one motor
  typedef struct packed {
    logic [7:0]  period;
    logic [7:0]  count;
    logic [15:0] steps;
    logic        dir;
    logic        level;
  } mot_state_t;

  localparam mot_state_t MOT_RESET = '{
    period: RESET_PERIOD,
    count:  8'd0,
    steps:  RESET_RUN,
    dir:    1'b0,
    level:  1'b0
  };

  // one timer tick for one motor
  function automatic mot_state_t mot_advance(mot_state_t s);
    mot_state_t r;
    r = s;
    if (s.steps != 16'd0) begin
      r.count = s.count + 8'd1;
      if (r.count == 8'd1) begin
        r.level = 1'b1;
      end
      // fall is applied after the rise
      if (r.count == {1'b0, s.period[7:1]}) begin
        r.level = 1'b0;
      end
      if (r.count == s.period) begin
        r.count = 8'd0;
        r.steps = s.steps - 16'd1;
      end
    end
    return r;
  endfunction

  // speed byte from a packet, zero leaves the motor alone
  function automatic mot_state_t mot_load(mot_state_t s, logic [7:0] raw,
                                          logic [15:0] run);
    mot_state_t r;
    r = s;
    if (raw != 8'd0) begin
      r.dir    = ~raw[7];
      r.period = raw[7] ? (8'd0 - raw) : raw;
      r.count  = 8'd0;
      r.steps  = run;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/msp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp interfaces: item, result and register write channels
// valid/ready channels with source and sink modports
// ----------------------------------------------------------------------------

interface msp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface msp_out_if #(
  parameter int MOTORS = msp_pkg::MOTORS_DEF
);
  logic              valid;
  logic              ready;
  logic [MOTORS-1:0] step_lines;
  logic [MOTORS-1:0] dir_lines;
  logic [MOTORS-1:0] busy_lines;
  logic              packet_taken;

  modport source (output valid, output step_lines, output dir_lines,
                  output busy_lines, output packet_taken, input ready);
  modport sink   (input valid, input step_lines, input dir_lines,
                  input busy_lines, input packet_taken, output ready);
endinterface

interface msp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [msp_pkg::CFG_IDX_W-1:0]      index;
  logic [msp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/multi_stepper_pulse_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stepper_pulse_generator_unit: step/direction generator for steppers
// timer ticks advance the motors, serial bytes build speed packets
// ----------------------------------------------------------------------------
// Usage: every transfer on in_i is either a timer tick (func 0) or one
// received serial byte (func 1), and gives exactly one result transfer on
// out_o with the step, direction and busy levels of all motors after the
// update, plus packet_taken for a byte that closed a packet whose first two
// bytes match header_word. A packet is PACKET_LEN bytes; byte 2 is ignored,
// bytes 3 and up are signed speeds for motors 0 and up. A bad header drops
// the packet and reception restarts at byte 0. The block takes one item per
// clock cycle, sustained while out_o accepts every result; out_o.ready low
// stalls the input. A result is offered on out_o once its item has passed
// the input register and its update has landed in the output register. The
// state memory is read every cycle. The rate is set by the read-modify-write
// loop on the motor state memory, which is closed by forwarding the last
// written row. Register writes on cfg_i are always taken and belong in idle
// periods only; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multi_stepper_pulse_generator_unit
  import msp_pkg::*;
#(
  parameter int MOTORS     = MOTORS_DEF,
  parameter int PACKET_LEN = PACKET_LEN_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  msp_in_if.sink     in_i,
  msp_out_if.source  out_o,
  msp_cfg_if.sink    cfg_i
);

  localparam int IDX_W = $clog2(PACKET_LEN);

  // one memory row holds the state of every motor
  typedef mot_state_t [MOTORS-1:0] mot_row_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] run_len_q;
  logic [15:0] hdr_word_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q  <= RESET_RUN;
      hdr_word_q <= RESET_HEADER;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RUN_LENGTH:  run_len_q  <= cfg_i.data;
        REG_HEADER_WORD: hdr_word_q <= cfg_i.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: input stage s1 feeds the output register
  // ---------------------------------------------------------------------
  logic       s1_valid_q;
  logic       s1_func_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic       s1_adv;
  logic       s1_fire;
  logic       in_fire;

  // s1 moves on when the output register is free or being emptied
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  // ---------------------------------------------------------------------
  // motor state memory, one row, read every cycle into a register
  // ---------------------------------------------------------------------
  mot_row_t mot_mem [0:0];
  mot_row_t ram_rd_q;
  mot_row_t wb_q;       // last row written
  logic     fwd_q;      // memory read data is one write behind
  logic     row_valid_q; // row written at least once since reset
  mot_row_t reset_row;
  mot_row_t row_cur;
  mot_row_t row_new;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mot_mem[0] <= row_new;
    end
    ram_rd_q <= mot_mem[0];
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      wb_q <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= 1'b0;
      row_valid_q <= 1'b0;
    end else begin
      fwd_q <= s1_fire;
      if (s1_fire) begin
        row_valid_q <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      reset_row[i] = MOT_RESET;
    end
  end

  // forward the write-back over the stale read; unwritten row reads as reset
  assign row_cur = fwd_q       ? wb_q :
                   row_valid_q ? ram_rd_q : reset_row;

  // ---------------------------------------------------------------------
  // packet reception
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] byte_idx_q;
  logic [IDX_W-1:0] byte_idx_d;
  logic [IDX_W-1:0] idx_eff;
  logic [7:0]       pkt_q [PACKET_LEN-1];  // all bytes but the last
  logic [7:0]       spd [MOTORS];
  logic             pkt_last;
  logic             hdr_ok;
  logic             taken_new;

  assign idx_eff  = (int'(byte_idx_q) >= PACKET_LEN) ? '0 : byte_idx_q;
  assign pkt_last = (int'(idx_eff) == PACKET_LEN - 1);
  assign hdr_ok   = ({pkt_q[0], pkt_q[1]} == hdr_word_q);

  // speed byte per motor; the last packet byte comes straight from s1,
  // a motor whose byte lies past the packet end sees zero and holds
  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      if (SPEED_BASE + i < PACKET_LEN - 1) begin
        spd[i] = pkt_q[SPEED_BASE + i];
      end else if (SPEED_BASE + i == PACKET_LEN - 1) begin
        spd[i] = s1_byte_q;
      end else begin
        spd[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_func_q && !pkt_last) begin
      for (int j = 0; j < PACKET_LEN - 1; j++) begin
        if (int'(idx_eff) == j) begin
          pkt_q[j] <= s1_byte_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
    end else if (s1_fire && s1_func_q) begin
      byte_idx_q <= byte_idx_d;
    end
  end

  // ---------------------------------------------------------------------
  // update of the motor row
  // ---------------------------------------------------------------------
  always_comb begin
    row_new    = row_cur;
    taken_new  = 1'b0;
    byte_idx_d = byte_idx_q;
    if (s1_func_q) begin
      if (!pkt_last) begin
        byte_idx_d = idx_eff + IDX_W'(1);
      end else begin
        // packet complete, good or bad reception restarts
        byte_idx_d = '0;
        if (hdr_ok) begin
          taken_new = 1'b1;
          for (int i = 0; i < MOTORS; i++) begin
            row_new[i] = mot_load(row_cur[i], spd[i], run_len_q);
          end
        end
      end
    end else begin
      for (int i = 0; i < MOTORS; i++) begin
        row_new[i] = mot_advance(row_cur[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic [MOTORS-1:0] step_q;
  logic [MOTORS-1:0] dir_q;
  logic [MOTORS-1:0] busy_q;
  logic              taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int i = 0; i < MOTORS; i++) begin
        step_q[i] <= row_new[i].level;
        dir_q[i]  <= row_new[i].dir;
        busy_q[i] <= (row_new[i].steps != 16'd0);
      end
      taken_q <= taken_new;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.step_lines   = step_q;
  assign out_o.dir_lines    = dir_q;
  assign out_o.busy_lines   = busy_q;
  assign out_o.packet_taken = taken_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(byte_idx_q) < PACKET_LEN)
    else $error("packet byte index out of range");

  a_tick_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_func_q |=> !taken_q)
    else $error("tick reported a packet");

  a_take_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && taken_new |=> byte_idx_q == '0)
    else $error("reception not restarted after packet");

  a_fwd_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> fwd_q && row_valid_q && out_valid_q)
    else $error("write-back not forwarded");
`endif

endmodule
`default_nettype wire
